>>> hdl/ffsa_pkg.sv
// Shared types and field widths for the first-fit slot allocator.
package ffsa_pkg;

	localparam int TAG_W   = 8;
	localparam int SIZE_W  = 5;
	localparam int INDEX_W = 4;
	localparam int LAST_W  = 4;
	localparam int FREE_W  = 5;
	localparam int OCC_W   = 16;

	localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
	localparam logic [TAG_W-1:0] TAG_NONE = '0;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_FULL  = 2'd1,
		ST_BADSZ = 2'd2,
		ST_FREED = 2'd3
	} status_t;

endpackage

>>> hdl/ffsa_tag_ram.sv
// Slot tag store: one write port, one read port, registered read data.
module ffsa_tag_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [ffsa_pkg::TAG_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [ffsa_pkg::TAG_W-1:0] rdata
);
	import ffsa_pkg::*;

	logic [TAG_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/first_fit_slot_allocator.sv
// First-fit contiguous slot allocator: control sequencer and occupancy tracking.
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be taken then, as the block
// cannot hold it. Slot tags live in a one-read one-write RAM; an occupancy
// bit per slot (cleared by reset) marks which RAM entries are live, so no
// clearing pass is needed after reset. Request steps: an allocate scans the
// slots from slot 0, one scan step per slot, until a free run of size slots
// ends at slot L, then does one RAM write per granted slot, then reports; an
// allocate that finds no run scans every slot, then reports; a free of an owned
// slot does a tag fetch, then a sweep reading one RAM entry per cycle; a
// size-zero allocate or a free of an unowned or out-of-range slot just reports.
module first_fit_slot_allocator #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffsa_pkg::cmd_t                command,
	input  logic [ffsa_pkg::SIZE_W-1:0]   alloc_size,
	input  logic [ffsa_pkg::INDEX_W-1:0]  slot_index,
	output logic                          done,
	output ffsa_pkg::status_t             status,
	output logic [ffsa_pkg::LAST_W-1:0]   last_slot,
	output logic [ffsa_pkg::TAG_W-1:0]    granted_tag,
	output logic [ffsa_pkg::FREE_W-1:0]   free_slots,
	output logic [ffsa_pkg::OCC_W-1:0]    occupancy
);
	import ffsa_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] ALL_FREE = CNT_W'(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_FETCH,
		S_SWEEP,
		S_REPORT
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] run_q;
	logic [SIZE_W-1:0] left_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  last_q;
	logic [TAG_W-1:0]  victim_q;
	logic [TAG_W-1:0]  tag_out_q;
	logic [TAG_W-1:0]  last_tag_q;
	status_t           stat_q;
	logic [SLOTS-1:0]  occ_q;
	logic [CNT_W-1:0]  free_cnt_q;

	logic              done_q;
	status_t           status_q;
	logic [LAST_W-1:0] last_slot_q;
	logic [TAG_W-1:0]  granted_tag_q;
	logic [FREE_W-1:0] free_slots_q;
	logic [OCC_W-1:0]  occupancy_q;

	logic [IDX_W-1:0]  idx_in;
	logic              idx_ok;
	logic [TAG_W-1:0]  new_tag;
	logic [SIZE_W-1:0] run_inc;
	logic              slot_free;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr;
	logic [TAG_W-1:0]  ram_rdata;

	// request decode and next tag
	assign idx_in    = IDX_W'(slot_index);
	assign idx_ok    = (int'(slot_index) < SLOTS);
	assign new_tag   = (last_tag_q == TAG_MAX) ? TAG_W'(1) : last_tag_q + TAG_W'(1);
	assign run_inc   = run_q + SIZE_W'(1);
	assign slot_free = !occ_q[ptr_q];

	// RAM port steering: writes only while filling; reads the named slot when idle
	assign ram_we = (state_q == S_FILL);
	always_comb begin
		unique case (state_q)
			S_IDLE:  ram_raddr = idx_in;
			S_SWEEP: ram_raddr = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
			default: ram_raddr = '0;
		endcase
	end

	ffsa_tag_ram #(
		.DEPTH (SLOTS),
		.AW    (IDX_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (new_tag),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, pool bookkeeping and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			size_q        <= '0;
			run_q         <= '0;
			left_q        <= '0;
			ptr_q         <= '0;
			last_q        <= '0;
			victim_q      <= '0;
			tag_out_q     <= '0;
			last_tag_q    <= '0;
			stat_q        <= ST_FREED;
			occ_q         <= '0;
			free_cnt_q    <= ALL_FREE;
			done_q        <= 1'b0;
			status_q      <= ST_FREED;
			last_slot_q   <= '0;
			granted_tag_q <= '0;
			free_slots_q  <= '0;
			occupancy_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						last_q    <= '0;
						tag_out_q <= TAG_NONE;
						ptr_q     <= '0;
						run_q     <= '0;
						size_q    <= alloc_size;
						if (command == CMD_ALLOC) begin
							if (alloc_size == '0) begin
								stat_q  <= ST_BADSZ;
								state_q <= S_REPORT;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							stat_q <= ST_FREED;
							if (idx_ok && occ_q[idx_in]) begin
								state_q <= S_FETCH;
							end else begin
								state_q <= S_REPORT;
							end
						end
					end
				end
				// one slot per cycle; first run reaching the size ends lowest
				S_SCAN: begin
					if (slot_free && run_inc == size_q) begin
						last_q  <= ptr_q;
						left_q  <= size_q;
						state_q <= S_FILL;
					end else begin
						run_q <= slot_free ? run_inc : '0;
						if (ptr_q == LAST_IDX) begin
							stat_q  <= ST_FULL;
							state_q <= S_REPORT;
						end else begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end
				end
				// write the tag back down the run, one slot per cycle
				S_FILL: begin
					occ_q[ptr_q] <= 1'b1;
					free_cnt_q   <= free_cnt_q - CNT_W'(1);
					left_q       <= left_q - SIZE_W'(1);
					ptr_q        <= ptr_q - IDX_W'(1);
					if (left_q == SIZE_W'(1)) begin
						last_tag_q <= new_tag;
						tag_out_q  <= new_tag;
						stat_q     <= ST_ALLOC;
						state_q    <= S_REPORT;
					end
				end
				// owner tag of the named slot is back from the RAM
				S_FETCH: begin
					victim_q <= ram_rdata;
					ptr_q    <= '0;
					state_q  <= S_SWEEP;
				end
				// read data belongs to ptr_q; next address already issued
				S_SWEEP: begin
					if (occ_q[ptr_q] && ram_rdata == victim_q) begin
						occ_q[ptr_q] <= 1'b0;
						free_cnt_q   <= free_cnt_q + CNT_W'(1);
					end
					if (ptr_q == LAST_IDX) begin
						state_q <= S_REPORT;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				S_REPORT: begin
					done_q        <= 1'b1;
					status_q      <= stat_q;
					last_slot_q   <= LAST_W'(last_q);
					granted_tag_q <= tag_out_q;
					free_slots_q  <= FREE_W'(free_cnt_q);
					occupancy_q   <= OCC_W'(occ_q);
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign last_slot   = last_slot_q;
	assign granted_tag = granted_tag_q;
	assign free_slots  = free_slots_q;
	assign occupancy   = occupancy_q;

`ifndef SYNTHESIS
	// free counter tracks the occupancy bits exactly
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(free_cnt_q) + $countones(occ_q) == SLOTS)
		else $error("free slot count out of step with occupancy");

	// a fill never lands on an owned slot
	a_fill_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> !occ_q[ptr_q])
		else $error("fill overwrites an owned slot");

	// a result strobe follows the report step
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_REPORT))
		else $error("result strobe without report step");

	// a granted run always carries a non-zero tag
	a_grant_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_ALLOC) |-> (granted_tag_q != TAG_NONE))
		else $error("allocation granted with zero tag");
`endif

endmodule
